// File: src/gge_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gge_pkg;

    // Queue depth between the front and the back
    localparam int QUEUE_DEPTH = 2;

    // Register values after reset
    localparam logic [15:0] RESET_ORIGIN_X = 16'd0;
    localparam logic [15:0] RESET_ORIGIN_Y = 16'd0;
    localparam logic [15:0] RESET_WIDTH    = 16'd16;
    localparam logic [2:0]  RESET_BPP      = 3'd1;
    localparam logic        RESET_DARK     = 1'b1;

    // Gray depth codes
    localparam logic [2:0] BPP_2 = 3'd2;
    localparam logic [2:0] BPP_3 = 3'd3;
    localparam logic [2:0] BPP_4 = 3'd4;

    // Colours of the one-bit mode
    localparam logic [15:0] MONO_DARK  = 16'h0000;
    localparam logic [15:0] MONO_LIGHT = 16'hFFFF;

    typedef enum logic [2:0] {
        REG_ORIGIN_X = 3'd0,
        REG_ORIGIN_Y = 3'd1,
        REG_WIDTH    = 3'd2,
        REG_BPP      = 3'd3,
        REG_DARK     = 3'd4
    } reg_index_t;

    typedef enum logic [2:0] {
        KIND_MONO  = 3'd0,
        KIND_GRAY2 = 3'd1,
        KIND_GRAY3 = 3'd2,
        KIND_GRAY4 = 3'd3,
        KIND_NONE  = 3'd4
    } kind_t;

    // One classified word: pixel codes sit left-aligned in bits
    typedef struct packed {
        kind_t       kind;
        logic [23:0] bits;
        logic        last_byte;
    } item_t;

    typedef struct packed {
        logic [15:0] origin_x;
        logic [15:0] origin_y;
        logic [15:0] glyph_width;
        logic        dark_on_light;
    } cfg_t;

    // Index of the final pixel position of a word
    function automatic logic [2:0] last_step(kind_t kind);
        logic [2:0] n;
        n = 3'd0;
        case (kind)
            KIND_MONO:  n = 3'd7;
            KIND_GRAY2: n = 3'd3;
            KIND_GRAY3: n = 3'd7;
            KIND_GRAY4: n = 3'd1;
            default:    n = 3'd0;
        endcase
        return n;
    endfunction

    // Apply polarity, scale a gray code to 8 bits, keep the top 5 bits
    function automatic logic [4:0] gray5(kind_t kind, logic [3:0] code, logic dark);
        logic [3:0] v;
        logic [7:0] level;
        v     = code;
        level = 8'd0;
        case (kind)
            KIND_GRAY2: begin
                if (dark) v = 4'd3 - code;
                case (v[1:0])
                    2'd0:    level = 8'd0;
                    2'd1:    level = 8'd83;
                    2'd2:    level = 8'd166;
                    default: level = 8'd250;
                endcase
            end
            KIND_GRAY3: begin
                if (dark) v = 4'd7 - code;
                case (v[2:0])
                    3'd0:    level = 8'd0;
                    3'd1:    level = 8'd36;
                    3'd2:    level = 8'd72;
                    3'd3:    level = 8'd109;
                    3'd4:    level = 8'd145;
                    3'd5:    level = 8'd182;
                    3'd6:    level = 8'd218;
                    default: level = 8'd255;
                endcase
            end
            KIND_GRAY4: begin
                if (dark) v = 4'd15 - code;
                // 17 * v fits exactly as the code repeated
                level = {v, v};
            end
            default: level = 8'd0;
        endcase
        return level[7:3];
    endfunction

    function automatic logic [15:0] pack565(logic [4:0] g);
        return {g, g, 1'b0, g};
    endfunction

endpackage

`default_nettype wire

// File: src/gge_front.sv
`timescale 1ns / 1ps
`default_nettype none

module gge_front (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire logic [7:0]     s_glyph_byte,
    input  wire logic           s_glyph_end,
    input  wire logic [2:0]     bits_per_pixel,
    input  wire logic           home,
    output logic                q_valid,
    input  wire logic           q_ready,
    output gge_pkg::item_t      q_item
);

    logic [1:0] phase_reg;
    logic [1:0] phase_next;
    logic [7:0] held0_reg;
    logic [7:0] held1_reg;
    logic       push;
    logic       accept;

    assign s_ready = q_ready;
    assign accept  = s_valid && q_ready;
    assign q_valid = s_valid && push;

    // Classify the incoming word
    always_comb begin
        push             = 1'b1;
        q_item.last_byte = s_glyph_end;
        q_item.bits      = {s_glyph_byte, 16'h0000};
        q_item.kind      = gge_pkg::KIND_MONO;
        unique case (bits_per_pixel)
            gge_pkg::BPP_2: q_item.kind = gge_pkg::KIND_GRAY2;
            gge_pkg::BPP_4: q_item.kind = gge_pkg::KIND_GRAY4;
            gge_pkg::BPP_3: begin
                if (phase_reg == 2'd2) begin
                    q_item.kind = gge_pkg::KIND_GRAY3;
                    q_item.bits = {held0_reg, held1_reg, s_glyph_byte};
                end else begin
                    // partial group: only a glyph end travels on
                    q_item.kind = gge_pkg::KIND_NONE;
                    push        = s_glyph_end;
                end
            end
            default: q_item.kind = gge_pkg::KIND_MONO;
        endcase
    end

    // Advance the three-byte group phase
    always_comb begin
        phase_next = phase_reg;
        if (home) begin
            phase_next = 2'd0;
        end else if (accept) begin
            if (s_glyph_end) begin
                phase_next = 2'd0;
            end else if (bits_per_pixel == gge_pkg::BPP_3) begin
                phase_next = (phase_reg == 2'd2) ? 2'd0 : phase_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= 2'd0;
        end else begin
            phase_reg <= phase_next;
        end
    end

    // Hold the first two bytes of a group
    always_ff @(posedge aclk) begin
        if (accept && bits_per_pixel == gge_pkg::BPP_3) begin
            if (phase_reg == 2'd0) held0_reg <= s_glyph_byte;
            if (phase_reg == 2'd1) held1_reg <= s_glyph_byte;
        end
    end

endmodule

`default_nettype wire

// File: src/gge_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module gge_queue #(
    parameter int DEPTH = gge_pkg::QUEUE_DEPTH
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire gge_pkg::item_t  in_item,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output gge_pkg::item_t       out_item
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    gge_pkg::item_t mem [DEPTH];
    logic [AW-1:0]  wr_ptr_reg;
    logic [AW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  count_reg;
    logic           push;
    logic           pop;

    assign in_ready  = count_reg != CW'(DEPTH);
    assign out_valid = count_reg != '0;
    assign out_item  = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) mem[wr_ptr_reg] <= in_item;
    end

    // Advance pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CW'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

// File: src/gge_back.sv
`timescale 1ns / 1ps
`default_nettype none

module gge_back (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire gge_pkg::item_t  q_item,
    input  wire logic            q_valid,
    output logic                 q_ready,
    input  wire gge_pkg::cfg_t   cfg,
    input  wire gge_pkg::cfg_t   cfg_next,
    input  wire logic            home,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output logic [15:0]          m_pixel_x,
    output logic [15:0]          m_pixel_y,
    output logic [15:0]          m_pixel_color,
    output logic                 m_run_last
);

    // current word
    logic                cur_valid_reg;
    gge_pkg::kind_t      kind_reg;
    logic [23:0]         sr_reg;
    logic                end_reg;
    logic [2:0]          step_reg;

    // cursor
    logic [15:0]         cursor_x_reg;
    logic [15:0]         cursor_y_reg;
    logic [15:0]         col_reg;

    // pending pixel, waiting to learn whether it ends its word
    logic                p_valid_reg;
    logic                p_last_reg;
    logic [15:0]         p_x_reg;
    logic [15:0]         p_y_reg;
    logic [15:0]         p_color_reg;

    // output register
    logic                o_valid_reg;
    logic                o_last_reg;
    logic [15:0]         o_x_reg;
    logic [15:0]         o_y_reg;
    logic [15:0]         o_color_reg;

    logic                show_bit;
    logic                shows;
    logic                o_free;
    logic                step_go;
    logic                final_step;
    logic                item_done;
    logic                rel;
    logic                wrap;
    logic                advance;
    logic [16:0]         padded;
    logic [3:0]          code;
    logic [4:0]          shamt;
    logic [15:0]         color;

    // Pick the pixel code at the top of the shift register
    always_comb begin
        code     = 4'd0;
        shamt    = 5'd1;
        show_bit = 1'b1;
        case (kind_reg)
            gge_pkg::KIND_MONO: begin
                code     = {3'b000, sr_reg[23]};
                show_bit = sr_reg[23];
            end
            gge_pkg::KIND_GRAY2: begin
                code  = {2'b00, sr_reg[23:22]};
                shamt = 5'd2;
            end
            gge_pkg::KIND_GRAY3: begin
                code  = {1'b0, sr_reg[23:21]};
                shamt = 5'd3;
            end
            gge_pkg::KIND_GRAY4: begin
                code  = sr_reg[23:20];
                shamt = 5'd4;
            end
            default: show_bit = 1'b0;
        endcase
    end

    assign color = (kind_reg == gge_pkg::KIND_MONO)
                 ? (cfg.dark_on_light ? gge_pkg::MONO_DARK : gge_pkg::MONO_LIGHT)
                 : gge_pkg::pack565(gge_pkg::gray5(kind_reg, code, cfg.dark_on_light));

    // Step control and hand-off between pending and output registers
    assign padded     = ({1'b0, cfg.glyph_width} + 17'd7) & ~17'd7;
    assign wrap       = ({1'b0, col_reg} + 17'd1) >= padded;
    assign shows      = cur_valid_reg && show_bit && (col_reg < cfg.glyph_width);
    assign o_free     = !o_valid_reg || m_ready;
    assign step_go    = cur_valid_reg && (!shows || !p_valid_reg || o_free);
    assign final_step = step_reg == gge_pkg::last_step(kind_reg);
    assign item_done  = step_go && final_step;
    assign q_ready    = !cur_valid_reg || item_done;
    assign rel        = p_valid_reg && o_free && (p_last_reg || (step_go && shows));
    assign advance    = step_go && (kind_reg != gge_pkg::KIND_NONE);

    assign m_valid       = o_valid_reg;
    assign m_pixel_x     = o_x_reg;
    assign m_pixel_y     = o_y_reg;
    assign m_pixel_color = o_color_reg;
    assign m_run_last    = o_last_reg;

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            step_reg      <= 3'd0;
            cursor_x_reg  <= gge_pkg::RESET_ORIGIN_X;
            cursor_y_reg  <= gge_pkg::RESET_ORIGIN_Y;
            col_reg       <= 16'd0;
            p_valid_reg   <= 1'b0;
            p_last_reg    <= 1'b0;
            o_valid_reg   <= 1'b0;
        end else begin
            // word sequencing
            if (q_ready) begin
                cur_valid_reg <= q_valid;
                step_reg      <= 3'd0;
            end else if (step_go) begin
                step_reg <= step_reg + 3'd1;
            end

            // cursor
            if (home) begin
                cursor_x_reg <= cfg_next.origin_x;
                cursor_y_reg <= cfg_next.origin_y;
                col_reg      <= 16'd0;
            end else if (item_done && end_reg) begin
                cursor_x_reg <= cfg.origin_x;
                cursor_y_reg <= cfg.origin_y;
                col_reg      <= 16'd0;
            end else if (advance) begin
                if (wrap) begin
                    cursor_x_reg <= cfg.origin_x;
                    cursor_y_reg <= cursor_y_reg + 16'd1;
                    col_reg      <= 16'd0;
                end else begin
                    cursor_x_reg <= cursor_x_reg + 16'd1;
                    col_reg      <= col_reg + 16'd1;
                end
            end

            // pending pixel
            if (step_go && shows) begin
                p_valid_reg <= 1'b1;
                p_last_reg  <= final_step;
            end else if (rel) begin
                p_valid_reg <= 1'b0;
            end else if (item_done && p_valid_reg) begin
                p_last_reg <= 1'b1;
            end

            // output register
            if (rel) begin
                o_valid_reg <= 1'b1;
            end else if (m_ready) begin
                o_valid_reg <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (q_ready && q_valid) begin
            kind_reg <= q_item.kind;
            sr_reg   <= q_item.bits;
            end_reg  <= q_item.last_byte;
        end else if (step_go) begin
            sr_reg <= sr_reg << shamt;
        end
        if (step_go && shows) begin
            p_x_reg     <= cursor_x_reg;
            p_y_reg     <= cursor_y_reg;
            p_color_reg <= color;
        end
        if (rel) begin
            o_x_reg     <= p_x_reg;
            o_y_reg     <= p_y_reg;
            o_color_reg <= p_color_reg;
            o_last_reg  <= p_last_reg;
        end
    end

endmodule

`default_nettype wire

// File: src/gray_glyph_to_rgb565_expander.sv
`timescale 1ns / 1ps
`default_nettype none

// Packed grayscale glyph expander: glyph bytes in, RGB565 pixels out.
// Input channel s_*: one glyph byte a word, MSB first; s_glyph_end marks the
// last byte of a glyph, after which cursor and 3-bit group phase return home.
// Output channel m_*: one pixel a word with its x, y and colour; m_run_last
// flags the final pixel of a byte or 3-bit group. Clipped pixels and clear bits of
// 1-bit data take their slot but produce no word.
// Configuration channel cfg_*: cfg_ready is always high; any write to a known
// index sends the cursor back to the origin. Write only while the block idles.
// Throughput: the back-end pixel stepper handles one pixel position a cycle
// unless a shown pixel has nowhere to go; a byte spans 8 positions at 1 or 3
// bits per pixel (the first two bytes of a 3-bit group cost none there), 4 at
// 2 bits and 2 at 4 bits. Bytes are taken every cycle while the front queue
// has room. A shown pixel passes the queue, current-word, pending and output
// registers; the final shown pixel of a byte waits until its last position.
// Reset clears the queue and the pixel valid flags and restores the register
// defaults. A stall on m_ready holds the output word; the stepper keeps going
// over hidden positions and stops only when a shown pixel has nowhere to go.
module gray_glyph_to_rgb565_expander #(
    parameter int QUEUE_DEPTH = gge_pkg::QUEUE_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_glyph_byte,
    input  wire logic        s_glyph_end,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [15:0]      m_pixel_x,
    output logic [15:0]      m_pixel_y,
    output logic [15:0]      m_pixel_color,
    output logic             m_run_last
);

    gge_pkg::cfg_t   cfg_reg;
    gge_pkg::cfg_t   cfg_next;
    logic [2:0]      bpp_reg;
    logic [2:0]      bpp_next;
    logic            home;
    logic            fq_valid;
    logic            fq_ready;
    gge_pkg::item_t  fq_item;
    logic            qb_valid;
    logic            qb_ready;
    gge_pkg::item_t  qb_item;

    assign cfg_ready = 1'b1;

    // Decode register writes
    always_comb begin
        cfg_next = cfg_reg;
        bpp_next = bpp_reg;
        home     = 1'b0;
        if (cfg_valid) begin
            home = 1'b1;
            unique case (cfg_index)
                gge_pkg::REG_ORIGIN_X: cfg_next.origin_x      = cfg_data;
                gge_pkg::REG_ORIGIN_Y: cfg_next.origin_y      = cfg_data;
                gge_pkg::REG_WIDTH:    cfg_next.glyph_width   = cfg_data;
                gge_pkg::REG_BPP:      bpp_next               = cfg_data[2:0];
                gge_pkg::REG_DARK:     cfg_next.dark_on_light = cfg_data[0];
                default:               home                   = 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.origin_x      <= gge_pkg::RESET_ORIGIN_X;
            cfg_reg.origin_y      <= gge_pkg::RESET_ORIGIN_Y;
            cfg_reg.glyph_width   <= gge_pkg::RESET_WIDTH;
            cfg_reg.dark_on_light <= gge_pkg::RESET_DARK;
            bpp_reg               <= gge_pkg::RESET_BPP;
        end else begin
            cfg_reg <= cfg_next;
            bpp_reg <= bpp_next;
        end
    end

    gge_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_glyph_byte   (s_glyph_byte),
        .s_glyph_end    (s_glyph_end),
        .bits_per_pixel (bpp_reg),
        .home           (home),
        .q_valid        (fq_valid),
        .q_ready        (fq_ready),
        .q_item         (fq_item)
    );

    gge_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_item   (fq_item),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_item  (qb_item)
    );

    gge_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_item        (qb_item),
        .q_valid       (qb_valid),
        .q_ready       (qb_ready),
        .cfg           (cfg_reg),
        .cfg_next      (cfg_next),
        .home          (home),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_x     (m_pixel_x),
        .m_pixel_y     (m_pixel_y),
        .m_pixel_color (m_pixel_color),
        .m_run_last    (m_run_last)
    );

endmodule

`default_nettype wire

// File: src/gge_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module gge_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        cfg_valid,
    input wire logic        cfg_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [15:0] m_pixel_x,
    input wire logic [15:0] m_pixel_y,
    input wire logic [15:0] m_pixel_color,
    input wire logic        m_run_last
);

    // a stalled word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pixel_x) && $stable(m_pixel_y)
            && $stable(m_pixel_color) && $stable(m_run_last))
        else $error("stalled pixel word changed");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("pixel word present after reset");

    // register writes are never refused
    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

    // colour is a packed gray or a full white
    a_color_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_pixel_color == 16'hFFFF)
            || ((m_pixel_color[10:6] == m_pixel_color[15:11])
                && (m_pixel_color[4:0] == m_pixel_color[15:11])
                && !m_pixel_color[5]))
        else $error("pixel colour is not a gray level");

endmodule

bind gray_glyph_to_rgb565_expander gge_checker u_gge_checker (.*);

`default_nettype wire
